[hdl/rcpd_pkg.sv]
// Shared definitions for the remote command packet decoder.
// Holds motion codes, register indexes, text and button phase codes and the text tracker state.
// No dependencies.
package rcpd_pkg;

	// Motion command codes.
	localparam logic [2:0] MOTION_NONE     = 3'd0;
	localparam logic [2:0] MOTION_FORWARD  = 3'd1;
	localparam logic [2:0] MOTION_BACKWARD = 3'd2;
	localparam logic [2:0] MOTION_LEFT     = 3'd3;
	localparam logic [2:0] MOTION_RIGHT    = 3'd4;
	localparam logic [2:0] MOTION_STOP     = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_CENTER    = 1'b0;
	localparam logic CFG_DEAD_ZONE = 1'b1;

	// Text trimming phases.
	localparam logic [1:0] PH_LEAD  = 2'd0;
	localparam logic [1:0] PH_BODY  = 2'd1;
	localparam logic [1:0] PH_TRAIL = 2'd2;

	// Button string parser phases.
	localparam logic [2:0] BT_NOT    = 3'd0;
	localparam logic [2:0] BT_SKIP   = 3'd1;
	localparam logic [2:0] BT_SIGN   = 3'd2;
	localparam logic [2:0] BT_DIGITS = 3'd3;
	localparam logic [2:0] BT_DONE   = 3'd4;

	// Number of command words tracked by the text matcher.
	localparam int NUM_WORDS = 7;

	// Running state of the text decoder for the current packet.
	typedef struct packed {
		logic [1:0]           text_phase;
		logic [NUM_WORDS-1:0] word_candidates;
		logic [3:0]           char_position;
		logic [2:0]           button_phase;
		logic [2:0]           button_number;
	} text_state_t;

	localparam text_state_t TEXT_CLEAR = '{
		text_phase:      PH_LEAD,
		word_candidates: {NUM_WORDS{1'b1}},
		char_position:   4'd0,
		button_phase:    BT_NOT,
		button_number:   3'd0
	};

endpackage

[hdl/rcpd_text.sv]
// Text packet tracker: next-state logic for trimming, word matching and button parsing.
// Also gives the motion command that the updated state would produce at packet end.
// Depends on rcpd_pkg.
module rcpd_text (
	input  rcpd_pkg::text_state_t text_cur,
	input  logic [7:0]            data_byte,
	output rcpd_pkg::text_state_t text_nxt,
	output logic [2:0]            text_motion
);

	localparam logic [7:0] WORD_TEXT [rcpd_pkg::NUM_WORDS][8] = '{
		'{"f", "o", "r", "w", "a", "r", "d", 8'h00},
		'{"u", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"b", "a", "c", "k", "w", "a", "r", "d"},
		'{"d", "o", "w", "n", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"l", "e", "f", "t", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "i", "g", "h", "t", 8'h00, 8'h00, 8'h00},
		'{"s", "t", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [3:0] WORD_LEN [rcpd_pkg::NUM_WORDS] = '{
		4'd7, 4'd2, 4'd8, 4'd4, 4'd4, 4'd5, 4'd4
	};
	localparam logic [2:0] WORD_CMD [rcpd_pkg::NUM_WORDS] = '{
		rcpd_pkg::MOTION_FORWARD, rcpd_pkg::MOTION_FORWARD,
		rcpd_pkg::MOTION_BACKWARD, rcpd_pkg::MOTION_BACKWARD,
		rcpd_pkg::MOTION_LEFT, rcpd_pkg::MOTION_RIGHT, rcpd_pkg::MOTION_STOP
	};

	logic                           is_space;
	logic                           is_digit;
	logic [7:0]                     lower_byte;
	logic [2:0]                     digit_sat;
	logic [2:0]                     feed_phase;
	logic [2:0]                     feed_number;
	logic [rcpd_pkg::NUM_WORDS-1:0] cand;
	logic                           found;

	assign is_space   = (data_byte == 8'h20) || (data_byte >= 8'h09 && data_byte <= 8'h0D);
	assign is_digit   = (data_byte >= "0") && (data_byte <= "9");
	assign lower_byte = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
	// Anything above five behaves like five, so the digit saturates right away.
	assign digit_sat  = (data_byte[3:0] > 4'd5) ? 3'd5 : data_byte[2:0];

	// Button number parser, fed with every byte after the leading B.
	always_comb begin
		feed_phase  = text_cur.button_phase;
		feed_number = text_cur.button_number;
		unique case (text_cur.button_phase)
			rcpd_pkg::BT_SKIP: begin
				if (is_space) begin
					feed_phase = rcpd_pkg::BT_SKIP;
				end else if (data_byte == "+") begin
					feed_phase = rcpd_pkg::BT_SIGN;
				end else if (is_digit) begin
					feed_phase  = rcpd_pkg::BT_DIGITS;
					feed_number = digit_sat;
				end else begin
					feed_phase = rcpd_pkg::BT_DONE;
				end
			end
			rcpd_pkg::BT_SIGN: begin
				if (is_digit) begin
					feed_phase  = rcpd_pkg::BT_DIGITS;
					feed_number = digit_sat;
				end else begin
					feed_phase = rcpd_pkg::BT_DONE;
				end
			end
			rcpd_pkg::BT_DIGITS: begin
				if (is_digit) begin
					feed_number = (text_cur.button_number == 3'd0) ? digit_sat : 3'd5;
				end else begin
					feed_phase = rcpd_pkg::BT_DONE;
				end
			end
			default: begin
				feed_phase = text_cur.button_phase;
			end
		endcase
	end

	// Trimming and word matching.
	always_comb begin
		text_nxt = text_cur;
		cand     = text_cur.word_candidates;
		if (is_space) begin
			if (text_cur.text_phase != rcpd_pkg::PH_LEAD) begin
				text_nxt.button_phase  = feed_phase;
				text_nxt.button_number = feed_number;
				text_nxt.text_phase    = rcpd_pkg::PH_TRAIL;
			end
		end else begin
			// Whitespace inside the text rules out every word.
			if (text_cur.text_phase == rcpd_pkg::PH_TRAIL) begin
				cand = '0;
			end
			if (text_cur.text_phase == rcpd_pkg::PH_LEAD) begin
				text_nxt.button_phase = (data_byte == "B" || data_byte == "b") ?
					rcpd_pkg::BT_SKIP : rcpd_pkg::BT_NOT;
			end else begin
				text_nxt.button_phase  = feed_phase;
				text_nxt.button_number = feed_number;
			end
			for (int k = 0; k < rcpd_pkg::NUM_WORDS; k++) begin
				if (!(text_cur.char_position < WORD_LEN[k] &&
					WORD_TEXT[k][text_cur.char_position[2:0]] == lower_byte)) begin
					cand[k] = 1'b0;
				end
			end
			text_nxt.word_candidates = cand;
			if (text_cur.char_position != 4'hF) begin
				text_nxt.char_position = text_cur.char_position + 4'd1;
			end
			text_nxt.text_phase = rcpd_pkg::PH_BODY;
		end
	end

	// Command for the packet if it ended with this byte.
	always_comb begin
		text_motion = rcpd_pkg::MOTION_NONE;
		found       = 1'b0;
		for (int k = 0; k < rcpd_pkg::NUM_WORDS; k++) begin
			if (!found && text_nxt.word_candidates[k] &&
				text_nxt.char_position == WORD_LEN[k]) begin
				text_motion = WORD_CMD[k];
				found       = 1'b1;
			end
		end
		if (!found && text_nxt.button_phase != rcpd_pkg::BT_NOT) begin
			if (text_nxt.button_number >= 3'd1 && text_nxt.button_number <= 3'd4) begin
				text_motion = text_nxt.button_number;
			end else begin
				text_motion = rcpd_pkg::MOTION_STOP;
			end
		end
	end

endmodule

[hdl/remote_command_packet_decoder.sv]
// Top level of the remote command packet decoder: input handshake, packet state,
// joystick and single-character decoding, result register and configuration.
// Depends on rcpd_pkg and rcpd_text.

// The decoder takes one received packet a word at a time, data_byte with
// last_byte marking the final word, and gives one motion word per packet
// (0 none, 1 forward, 2 backward, 3 left, 4 right, 5 stop). A one-word
// packet is looked up as a single command character, a two-word packet is an
// X then Y joystick pair judged against the stick center and dead_zone, and a
// longer packet is text that is trimmed and matched against command words or
// read as a B button number. Each input word is decoded in the cycle it is
// accepted, so the block takes one word per clock while in_ready is high;
// the motion word appears on the output register in the cycle after the last
// word of its packet. in_ready drops only while a finished motion word sits
// in the output register and out_ready is low, since that register is the
// only place a result can wait. Configuration writes (index 0 stick center,
// index 1 dead_zone) are taken in any cycle and should be made between packets.
module remote_command_packet_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] motion,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	// Command for a packet of exactly one character.
	function automatic logic [2:0] single_cmd(input logic [7:0] c);
		logic [2:0] cmd;
		unique case (c)
			"F", "f", "1": cmd = rcpd_pkg::MOTION_FORWARD;
			"B", "b", "2": cmd = rcpd_pkg::MOTION_BACKWARD;
			"L", "l", "3": cmd = rcpd_pkg::MOTION_LEFT;
			"R", "r", "4": cmd = rcpd_pkg::MOTION_RIGHT;
			"S", "s", "0": cmd = rcpd_pkg::MOTION_STOP;
			default:       cmd = rcpd_pkg::MOTION_NONE;
		endcase
		return cmd;
	endfunction

	// Command for a joystick pair. Offsets are nine-bit signed, so the byte
	// difference never wraps; magnitudes under the dead zone count as zero.
	function automatic logic [2:0] pair_cmd(input logic [7:0] xb, input logic [7:0] yb,
		input logic [7:0] center, input logic [7:0] dz);
		logic [8:0] x;
		logic [8:0] y;
		logic [8:0] ax;
		logic [8:0] ay;
		logic [8:0] mx;
		logic [8:0] my;
		logic [2:0] cmd;
		x  = {1'b0, xb} - {1'b0, center};
		y  = {1'b0, yb} - {1'b0, center};
		ax = x[8] ? (9'd0 - x) : x;
		ay = y[8] ? (9'd0 - y) : y;
		mx = (ax < {1'b0, dz}) ? 9'd0 : ax;
		my = (ay < {1'b0, dz}) ? 9'd0 : ay;
		cmd = rcpd_pkg::MOTION_STOP;
		if (my > mx) begin
			if (my > {1'b0, dz}) begin
				cmd = y[8] ? rcpd_pkg::MOTION_BACKWARD : rcpd_pkg::MOTION_FORWARD;
			end
		end else begin
			if (mx > {1'b0, dz}) begin
				cmd = x[8] ? rcpd_pkg::MOTION_LEFT : rcpd_pkg::MOTION_RIGHT;
			end
		end
		return cmd;
	endfunction

	logic                  in_fire;
	logic [1:0]            byte_count_q;
	logic [7:0]            first_byte_q;
	rcpd_pkg::text_state_t text_q;
	rcpd_pkg::text_state_t text_nxt;
	logic [2:0]            text_motion;
	logic [2:0]            packet_motion;
	logic [7:0]            center_q;
	logic [7:0]            dead_zone_q;
	logic                  out_valid_q;
	logic [2:0]            motion_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign motion    = motion_q;

	rcpd_text u_text (
		.text_cur    (text_q),
		.data_byte   (data_byte),
		.text_nxt    (text_nxt),
		.text_motion (text_motion)
	);

	// The packet length chooses the decoding. For a pair, the Y byte is the
	// current word, so it is used straight from the port.
	always_comb begin
		unique case (byte_count_q)
			2'd0:    packet_motion = single_cmd(data_byte);
			2'd1:    packet_motion = pair_cmd(first_byte_q, data_byte, center_q, dead_zone_q);
			default: packet_motion = text_motion;
		endcase
	end

	// Packet state. The last word of a packet clears everything for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 2'd0;
			text_q       <= rcpd_pkg::TEXT_CLEAR;
		end else if (in_fire) begin
			if (last_byte) begin
				byte_count_q <= 2'd0;
				text_q       <= rcpd_pkg::TEXT_CLEAR;
			end else begin
				if (byte_count_q != 2'd3) begin
					byte_count_q <= byte_count_q + 2'd1;
				end
				text_q <= text_nxt;
			end
		end
	end

	// The first byte is only read while byte_count_q is one, after it is written.
	always_ff @(posedge clk) begin
		if (in_fire && byte_count_q == 2'd0) begin
			first_byte_q <= data_byte;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last_byte) begin
			motion_q <= packet_motion;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q    <= 8'd127;
			dead_zone_q <= 8'd30;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rcpd_pkg::CFG_CENTER:    center_q    <= cfg_data;
				rcpd_pkg::CFG_DEAD_ZONE: dead_zone_q <= cfg_data;
				default:                 center_q    <= center_q;
			endcase
		end
	end

	// The last word of a packet always yields a result and leaves clean state.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_byte |=> out_valid_q && byte_count_q == 2'd0 &&
			text_q.text_phase == rcpd_pkg::PH_LEAD)
		else $error("last word did not produce a result or clear the packet state");

	// Leading whitespace is the only phase in which no character has been counted.
	a_lead_position: assert property (@(posedge clk) disable iff (!arst_n)
		(text_q.text_phase == rcpd_pkg::PH_LEAD) == (text_q.char_position == 4'd0))
		else $error("text phase and character position disagree");

	// A button string can only start at the first non-blank character.
	a_button_after_lead: assert property (@(posedge clk) disable iff (!arst_n)
		text_q.button_phase != rcpd_pkg::BT_NOT |-> text_q.text_phase != rcpd_pkg::PH_LEAD)
		else $error("button parser active before any text character");

	// The button number never exceeds its saturation value.
	a_button_sat: assert property (@(posedge clk) disable iff (!arst_n)
		text_q.button_number <= 3'd5)
		else $error("button number above saturation value");

endmodule

[tb/rcpd_motion_checker.sv]
`timescale 1ns / 100ps
// Checker for the remote command packet decoder: follows the input, output and
// register write channels, predicts every motion word and compares it on arrival.
// Depends on rcpd_pkg for the motion, register, trimming and button phase codes.
module rcpd_motion_checker #(
	parameter bit CENTER_REG    = rcpd_pkg::CFG_CENTER,
	parameter bit DEAD_ZONE_REG = rcpd_pkg::CFG_DEAD_ZONE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [2:0] motion,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output int         mismatches,
	output int         pending,
	output int         checked
);

	localparam logic [7:0] CENTER_AT_RESET    = 8'd127;
	localparam logic [7:0] DEAD_ZONE_AT_RESET = 8'd30;

	logic [7:0]                     center_q;
	logic [7:0]                     dead_zone_q;
	logic [1:0]                     pkt_len;
	logic [7:0]                     x_byte;
	logic [7:0]                     y_byte;
	logic [1:0]                     trim_phase;
	logic [rcpd_pkg::NUM_WORDS-1:0] word_alive;
	logic [3:0]                     char_idx;
	logic [2:0]                     btn_phase;
	logic [2:0]                     btn_value;
	logic [2:0]                     motion_due [$];
	logic [2:0]                     due;
	logic [2:0]                     fresh;
	bit                             have_due;

	function automatic string cmd_word(int k);
		case (k)
		0: return "forward";
		1: return "up";
		2: return "backward";
		3: return "down";
		4: return "left";
		5: return "right";
		default: return "stop";
		endcase
	endfunction

	function automatic logic [2:0] word_motion(int k);
		case (k)
		0, 1: return rcpd_pkg::MOTION_FORWARD;
		2, 3: return rcpd_pkg::MOTION_BACKWARD;
		4: return rcpd_pkg::MOTION_LEFT;
		5: return rcpd_pkg::MOTION_RIGHT;
		default: return rcpd_pkg::MOTION_STOP;
		endcase
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void start_packet();
		pkt_len    = 2'd0;
		x_byte     = 8'd0;
		y_byte     = 8'd0;
		trim_phase = rcpd_pkg::PH_LEAD;
		word_alive = '1;
		char_idx   = 4'd0;
		btn_phase  = rcpd_pkg::BT_NOT;
		btn_value  = 3'd0;
	endfunction

	function automatic logic [2:0] char_motion(logic [7:0] c);
		case (c)
		"F", "f", "1": return rcpd_pkg::MOTION_FORWARD;
		"B", "b", "2": return rcpd_pkg::MOTION_BACKWARD;
		"L", "l", "3": return rcpd_pkg::MOTION_LEFT;
		"R", "r", "4": return rcpd_pkg::MOTION_RIGHT;
		"S", "s", "0": return rcpd_pkg::MOTION_STOP;
		default: return rcpd_pkg::MOTION_NONE;
		endcase
	endfunction

	// Offsets are taken at full integer width, which covers the 9-bit signed range.
	function automatic logic [2:0] pair_motion(logic [7:0] xb, logic [7:0] yb);
		int dz, x, y, ax, ay;
		dz = int'(dead_zone_q);
		x  = int'(xb) - int'(center_q);
		y  = int'(yb) - int'(center_q);
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		if (ax < dz) begin
			x  = 0;
			ax = 0;
		end
		if (ay < dz) begin
			y  = 0;
			ay = 0;
		end
		if (ay > ax) begin
			if (y > dz) return rcpd_pkg::MOTION_FORWARD;
			if (y < -dz) return rcpd_pkg::MOTION_BACKWARD;
		end else begin
			if (x > dz) return rcpd_pkg::MOTION_RIGHT;
			if (x < -dz) return rcpd_pkg::MOTION_LEFT;
		end
		return rcpd_pkg::MOTION_STOP;
	endfunction

	// Every digit above five gives stop just as five does, so the stored
	// number is held at five from the first digit on.
	function automatic void button_step(logic [7:0] c);
		int n;
		case (btn_phase)
		rcpd_pkg::BT_SKIP: begin
			if (is_blank(c)) begin
			end else if (c == "+") begin
				btn_phase = rcpd_pkg::BT_SIGN;
			end else if (is_num(c)) begin
				btn_value = (c > "5") ? 3'd5 : 3'(c - "0");
				btn_phase = rcpd_pkg::BT_DIGITS;
			end else begin
				btn_phase = rcpd_pkg::BT_DONE;
			end
		end
		rcpd_pkg::BT_SIGN: begin
			if (is_num(c)) begin
				btn_value = (c > "5") ? 3'd5 : 3'(c - "0");
				btn_phase = rcpd_pkg::BT_DIGITS;
			end else begin
				btn_phase = rcpd_pkg::BT_DONE;
			end
		end
		rcpd_pkg::BT_DIGITS: begin
			if (is_num(c)) begin
				n = int'(btn_value) * 10 + int'(c - "0");
				btn_value = n > 5 ? 3'd5 : 3'(n);
			end else begin
				btn_phase = rcpd_pkg::BT_DONE;
			end
		end
		default: begin
		end
		endcase
	endfunction

	function automatic void glyph_step(logic [7:0] c);
		logic [7:0] lc;
		string w;
		lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
		if (trim_phase == rcpd_pkg::PH_LEAD) begin
			btn_phase = (c == "B" || c == "b") ? rcpd_pkg::BT_SKIP : rcpd_pkg::BT_NOT;
		end else begin
			button_step(c);
		end
		for (int k = 0; k < rcpd_pkg::NUM_WORDS; k++) begin
			w = cmd_word(k);
			if (!(char_idx < w.len() && w[char_idx] == lc)) word_alive[k] = 1'b0;
		end
		if (char_idx != 4'd15) char_idx++;
		trim_phase = rcpd_pkg::PH_BODY;
	endfunction

	// Whitespace after the body moves to the trailing phase; any later
	// non-blank character means the text held inner whitespace.
	function automatic void text_step(logic [7:0] c);
		if (is_blank(c)) begin
			if (trim_phase != rcpd_pkg::PH_LEAD) begin
				button_step(c);
				trim_phase = rcpd_pkg::PH_TRAIL;
			end
		end else begin
			if (trim_phase == rcpd_pkg::PH_TRAIL) word_alive = '0;
			glyph_step(c);
		end
	endfunction

	function automatic logic [2:0] text_motion();
		string w;
		for (int k = 0; k < rcpd_pkg::NUM_WORDS; k++) begin
			w = cmd_word(k);
			if (word_alive[k] && char_idx == w.len()) return word_motion(k);
		end
		if (btn_phase != rcpd_pkg::BT_NOT) begin
			case (btn_value)
			3'd1: return rcpd_pkg::MOTION_FORWARD;
			3'd2: return rcpd_pkg::MOTION_BACKWARD;
			3'd3: return rcpd_pkg::MOTION_LEFT;
			3'd4: return rcpd_pkg::MOTION_RIGHT;
			default: return rcpd_pkg::MOTION_STOP;
			endcase
		end
		return rcpd_pkg::MOTION_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q    = CENTER_AT_RESET;
			dead_zone_q = DEAD_ZONE_AT_RESET;
			start_packet();
			motion_due.delete();
			mismatches = 0;
			checked    = 0;
			pending    = 0;
		end else begin
			// Compare first: a word accepted at this edge cannot produce a
			// result at the same edge.
			if (out_valid && out_ready) begin
				have_due = motion_due.size() != 0;
				if (have_due) begin
					due = motion_due.pop_front();
					checked++;
				end
				if (!have_due || motion !== due) begin
					mismatches++;
					if (mismatches <= 10) begin
						if (have_due)
							$display("%0t: motion mismatch, expected %0d, got %0d",
								$time, due, motion);
						else
							$display("%0t: motion mismatch, expected nothing, got %0d",
								$time, motion);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CENTER_REG) center_q = cfg_data;
				else if (cfg_index == DEAD_ZONE_REG) dead_zone_q = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (pkt_len == 2'd0) x_byte = data_byte;
				else if (pkt_len == 2'd1) y_byte = data_byte;
				text_step(data_byte);
				if (!last_byte) begin
					if (pkt_len != 2'd3) pkt_len++;
				end else begin
					case (pkt_len)
					2'd0: fresh = char_motion(data_byte);
					2'd1: fresh = pair_motion(x_byte, y_byte);
					default: fresh = text_motion();
					endcase
					motion_due.push_back(fresh);
					start_packet();
				end
			end
			pending = motion_due.size();
		end
	end

endmodule

[tb/tb_remote_command_packet_decoder.sv]
`timescale 1ns / 100ps
// Top of the remote command packet decoder testbench: clock, reset, packet
// stimulus, register settings and the verdict.
// Depends on rcpd_pkg, remote_command_packet_decoder and rcpd_motion_checker.
module tb_remote_command_packet_decoder;

	// Register indexes of the write channel.
	localparam bit REG_CENTER    = rcpd_pkg::CFG_CENTER;
	localparam bit REG_DEAD_ZONE = rcpd_pkg::CFG_DEAD_ZONE;

	// Rough number of input words for the random part, spread over the settings.
	localparam int RANDOM_WORDS = 1400;
	localparam int NUM_SETTINGS = 8;
	// Time for the result register to drain, with a comfortable margin.
	localparam int DRAIN_CYCLES = 8;
	// Many times the length of the slowest correct run of about 1400 words.
	localparam int CYCLE_LIMIT  = 400000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] motion;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [7:0] cfg_data;

	int mismatches;
	int pending;
	int checked;

	int cycles;
	int words_sent;
	int packets;
	int settings_used;

	// While calm is set neither side idles, giving back-to-back stretches.
	bit calm;

	// Register values as last written, used only to aim joystick stimulus at
	// the dead zone edges.
	logic [7:0] cur_center;
	logic [7:0] cur_dz;

	// Bytes of the packet being built.
	logic [7:0] pkt [$];

	string singles = "FfBbLlRrSs01234";

	remote_command_packet_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.motion    (motion),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rcpd_motion_checker #(
		.CENTER_REG    (REG_CENTER),
		.DEAD_ZONE_REG (REG_DEAD_ZONE)
	) i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.motion     (motion),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost motion word ends the run here.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d motion words outstanding.",
				cycles, pending);
			$display("simulation failed");
			$finish;
		end
	end

	// Receiving side. Before each motion word it holds ready low for a random
	// number of cycles, then keeps it high until a word is taken. Ready may be
	// high with nothing offered, which is allowed by the handshake.
	initial begin
		int hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 9);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// Offers one word after a random gap and returns at the falling edge that
	// follows its acceptance. Valid is left high so that a word sent with no
	// gap follows without a bubble; only a gap lowers it.
	task automatic send_word(input logic [7:0] b, input bit last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_byte <= b;
		last_byte <= last;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// Sends the packet under construction with the last mark on its final word.
	task automatic send_packet();
		logic [7:0] b;
		while (pkt.size() != 0) begin
			b = pkt.pop_front();
			send_word(b, pkt.size() == 0);
		end
		packets++;
		if ($urandom_range(0, 15) == 0) calm = !calm;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
		send_packet();
	endtask

	// Stops the sender until every motion word has come back, then lets the
	// block run empty before returning. Register writes only follow this.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input bit idx, input logic [7:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		if (idx == REG_CENTER) cur_center = val;
		else cur_dz = val;
	endtask

	task automatic apply_setting(input logic [7:0] center, input logic [7:0] dz);
		write_reg(REG_CENTER, center);
		write_reg(REG_DEAD_ZONE, dz);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic string word_name(int k);
		case (k)
		0: return "forward";
		1: return "up";
		2: return "backward";
		3: return "down";
		4: return "left";
		5: return "right";
		default: return "stop";
		endcase
	endfunction

	// Space or one of the control codes from tab to carriage return.
	task automatic add_blank();
		int r;
		r = $urandom_range(0, 5);
		pkt.push_back(r == 5 ? 8'h20 : 8'h09 + 8'(r));
	endtask

	// Mostly clean command words in random case with optional padding. A few
	// get a wrong letter, an inner blank, a dropped tail or an extra letter.
	task automatic build_word_text();
		string w;
		logic [7:0] c;
		int stop_at;
		w = word_name($urandom_range(0, rcpd_pkg::NUM_WORDS - 1));
		stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w.len() - 1) : w.len();
		repeat ($urandom_range(0, 2)) add_blank();
		for (int i = 0; i < stop_at; i++) begin
			c = w[i];
			if ($urandom_range(0, 1) == 1) c = c - 8'h20;
			if ($urandom_range(0, 19) == 0) c = 8'($urandom_range(0, 255));
			pkt.push_back(c);
			if (i < stop_at - 1 && $urandom_range(0, 24) == 0) add_blank();
		end
		if ($urandom_range(0, 9) == 0) pkt.push_back(8'("a" + $urandom_range(0, 25)));
		repeat ($urandom_range(0, 2)) add_blank();
		while (pkt.size() < 3) add_blank();
	endtask

	// A B, optional blanks, optional sign, a few digits and an optional tail.
	// Single digits dominate so that each button number is common.
	task automatic build_button_text();
		int ndig;
		int r;
		if ($urandom_range(0, 3) == 0) add_blank();
		pkt.push_back($urandom_range(0, 1) ? "B" : "b");
		repeat ($urandom_range(0, 2)) add_blank();
		r = $urandom_range(0, 5);
		if (r == 0) pkt.push_back("+");
		else if (r == 1) pkt.push_back("-");
		r = $urandom_range(0, 7);
		ndig = (r == 0) ? 0 : (r <= 5) ? 1 : (r == 6) ? 2 : $urandom_range(3, 6);
		repeat (ndig) pkt.push_back(8'("0" + $urandom_range(0, 9)));
		r = $urandom_range(0, 5);
		if (r == 0) pkt.push_back(8'($urandom_range(0, 255)));
		else if (r == 1) pkt.push_back(8'("0" + $urandom_range(0, 9)));
		repeat ($urandom_range(0, 2)) add_blank();
		while (pkt.size() < 3) add_blank();
	endtask

	// Joystick pairs aimed at the dead zone edges, the center, or anywhere.
	task automatic build_pair();
		logic [7:0] v;
		for (int a = 0; a < 2; a++) begin
			case ($urandom_range(0, 3))
			0: v = 8'(cur_center + cur_dz + $urandom_range(0, 2) - 1);
			1: v = 8'(cur_center - cur_dz + $urandom_range(0, 2) - 1);
			2: v = 8'(cur_center + $urandom_range(0, 8) - 4);
			default: v = 8'($urandom_range(0, 255));
			endcase
			pkt.push_back(v);
		end
	endtask

	task automatic build_packet();
		int kind;
		kind = $urandom_range(0, 19);
		if (kind < 3) begin
			if ($urandom_range(0, 1) == 1) pkt.push_back(singles[$urandom_range(0, 14)]);
			else pkt.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 8) begin
			build_pair();
		end else if (kind < 14) begin
			build_word_text();
		end else if (kind < 18) begin
			build_button_text();
		end else begin
			// Raw noise, at times long enough to saturate the character position.
			repeat ($urandom_range(3, 20)) pkt.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int phase_words;
		logic [7:0] c;
		logic [7:0] d;
		in_valid      = 1'b0;
		data_byte     = 8'd0;
		last_byte     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_CENTER;
		cfg_data      = 8'd0;
		calm          = 1'b0;
		words_sent    = 0;
		packets       = 0;
		settings_used = 0;
		cur_center    = 8'd127;
		cur_dz        = 8'd30;
		arst_n        = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed packets under the reset values: command characters, a zero
		// byte, joystick extremes, padded and upper case words, a signed button,
		// a button number too large to fit, and a word split by a blank.
		send_text("F");
		send_text("b");
		pkt.push_back(8'h00);
		send_packet();
		pkt.push_back(8'hff);
		pkt.push_back(8'h00);
		send_packet();
		pkt.push_back(8'h00);
		pkt.push_back(8'd127);
		send_packet();
		send_text(" up");
		send_text("LEFT");
		send_text("b+3");
		send_text("B99");
		send_text("le ft");
		settle();

		// Random packets under a series of register settings. Every change
		// waits until the decoder has handed back all pending motion words.
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			case (p)
			0: begin c = 8'd127; d = 8'd30; end
			1: begin c = 8'd0;   d = 8'd0;   end
			2: begin c = 8'd255; d = 8'd255; end
			3: begin c = 8'd128; d = 8'd1;   end
			4: begin c = 8'd0;   d = 8'd255; end
			5: begin c = 8'd255; d = 8'd0;   end
			default: begin
				c = 8'($urandom_range(0, 255));
				d = 8'($urandom_range(0, 80));
			end
			endcase
			apply_setting(c, d);
			phase_words = words_sent;
			while (words_sent - phase_words < RANDOM_WORDS / NUM_SETTINGS) begin
				build_packet();
				send_packet();
			end
			settle();
		end

		$display("Sent %0d packets in %0d input words under %0d register settings;",
			packets, words_sent, settings_used);
		$display("%0d motion words compared, %0d mismatches.", checked, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
